FILE: rtl/core/segi_pkg.sv
// shared types, constants and helpers for the segment intersection test
package segi_pkg;

    localparam int FIELD_W          = 16;
    localparam int COORD_W_DEFAULT  = 16;
    localparam int NUM_FIELDS       = 8;
    localparam int NUM_TESTS        = 4;
    localparam int S_TDATA_W        = NUM_FIELDS * FIELD_W;
    localparam int ORIENT_W         = 3;
    localparam int M_TDATA_W        = 16;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_CCW   = 3'd0,
        ORIENT_CW    = 3'd1,
        ORIENT_BACK  = 3'd2,
        ORIENT_FRONT = 3'd3,
        ORIENT_ON    = 3'd4
    } orient_t;

    // counter-clockwise and online back count as positive
    function automatic logic orient_pos(input orient_t code);
        return (code == ORIENT_CCW) || (code == ORIENT_BACK);
    endfunction

    // clockwise and online front count as negative
    function automatic logic orient_neg(input orient_t code);
        return (code == ORIENT_CW) || (code == ORIENT_FRONT);
    endfunction

    // sign product of one pair is zero or less
    function automatic logic pair_straddles(input orient_t c0, input orient_t c1);
        return !(orient_pos(c0) && orient_pos(c1)) && !(orient_neg(c0) && orient_neg(c1));
    endfunction

    function automatic logic segments_meet_of(input orient_t c0, input orient_t c1,
                                              input orient_t c2, input orient_t c3);
        return pair_straddles(c0, c1) && pair_straddles(c2, c3);
    endfunction

endpackage

FILE: rtl/core/segment_intersection_test.sv
// segment intersection test: four-stage pipelined orientation tests on two segments
//
// one request on the s_ stream carries two segments a and b, eight signed
// 16-bit coordinates packed in s_tdata. each coordinate is the low
// COORD_WIDTH bits of its field, sign extended. one result per request comes
// out on the m_ stream: the four orientation codes and the meet flag.
// a request passes the four register stages (difference, multiply, sum and
// classify/output); the first loads at the accepting edge. throughput is
// one request per cycle, limited only by the receiver; the multiply stage
// (eight products per test, each of two COORD_WIDTH+1 bit differences)
// sets the longest path.
// each stage holds a valid bit and advances when the stage after it is empty
// or moving, so bubbles are squeezed out and a stall on m_tready backs up
// stage by stage without losing or repeating a request; s_tready drops only
// when all four stages are full and the result is not taken.
// reset (aresetn low, synchronous) clears every valid bit; data registers
// are not reset. after reset s_tready is high and m_tvalid is low.
module segment_intersection_test #(
    parameter int COORD_WIDTH = segi_pkg::COORD_W_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    //          seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (16 bits each)
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [segi_pkg::S_TDATA_W-1:0]   s_tdata,
    // result: segments_meet, orient_a_bstart, orient_a_bend, orient_b_astart,
    //         orient_b_aend (3 bits each), zero pad to 16 bits
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [segi_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int FW   = segi_pkg::FIELD_W;
    localparam int NT   = segi_pkg::NUM_TESTS;
    localparam int NF   = segi_pkg::NUM_FIELDS;
    localparam int MINW = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
    localparam int DW   = COORD_WIDTH + 1;     // coordinate difference
    localparam int PW   = 2 * DW;              // one product
    localparam int SW   = PW + 1;              // sum of two products
    localparam int OW   = segi_pkg::ORIENT_W;

    // point numbers: 0 a start, 1 a end, 2 b start, 3 b end
    localparam int P0_PT [NT] = '{0, 0, 2, 2};
    localparam int Q1_PT [NT] = '{1, 1, 3, 3};
    localparam int Q2_PT [NT] = '{2, 3, 0, 1};

    // stage advance chain, bubble collapsing
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !m_valid_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // coordinate extraction: low COORD_WIDTH bits, sign taken from bit COORD_WIDTH-1
    logic [COORD_WIDTH-1:0] coord [NF];

    always_comb begin
        for (int i = 0; i < NF; i++) begin
            coord[i] = '0;
            coord[i][MINW-1:0] = s_tdata[i*FW +: MINW];
        end
    end

    // stage 1: edge vectors u = q1 - p0, v = q2 - p0
    logic [DW-1:0] ux_reg [NT], uy_reg [NT], vx_reg [NT], vy_reg [NT];
    logic [DW-1:0] ux_next [NT], uy_next [NT], vx_next [NT], vy_next [NT];

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            ux_next[t] = {coord[2*Q1_PT[t]][COORD_WIDTH-1], coord[2*Q1_PT[t]]}
                       - {coord[2*P0_PT[t]][COORD_WIDTH-1], coord[2*P0_PT[t]]};
            uy_next[t] = {coord[2*Q1_PT[t]+1][COORD_WIDTH-1], coord[2*Q1_PT[t]+1]}
                       - {coord[2*P0_PT[t]+1][COORD_WIDTH-1], coord[2*P0_PT[t]+1]};
            vx_next[t] = {coord[2*Q2_PT[t]][COORD_WIDTH-1], coord[2*Q2_PT[t]]}
                       - {coord[2*P0_PT[t]][COORD_WIDTH-1], coord[2*P0_PT[t]]};
            vy_next[t] = {coord[2*Q2_PT[t]+1][COORD_WIDTH-1], coord[2*Q2_PT[t]+1]}
                       - {coord[2*P0_PT[t]+1][COORD_WIDTH-1], coord[2*P0_PT[t]+1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_tvalid;
        end
        if (adv1 && s_tvalid) begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    // stage 2: the eight products of each test
    logic signed [PW-1:0] p_uxvy_reg [NT], p_uyvx_reg [NT], p_uxvx_reg [NT], p_uyvy_reg [NT];
    logic signed [PW-1:0] p_uxux_reg [NT], p_uyuy_reg [NT], p_vxvx_reg [NT], p_vyvy_reg [NT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2 && v1_reg) begin
            for (int t = 0; t < NT; t++) begin
                p_uxvy_reg[t] <= PW'($signed(ux_reg[t])) * PW'($signed(vy_reg[t]));
                p_uyvx_reg[t] <= PW'($signed(uy_reg[t])) * PW'($signed(vx_reg[t]));
                p_uxvx_reg[t] <= PW'($signed(ux_reg[t])) * PW'($signed(vx_reg[t]));
                p_uyvy_reg[t] <= PW'($signed(uy_reg[t])) * PW'($signed(vy_reg[t]));
                p_uxux_reg[t] <= PW'($signed(ux_reg[t])) * PW'($signed(ux_reg[t]));
                p_uyuy_reg[t] <= PW'($signed(uy_reg[t])) * PW'($signed(uy_reg[t]));
                p_vxvx_reg[t] <= PW'($signed(vx_reg[t])) * PW'($signed(vx_reg[t]));
                p_vyvy_reg[t] <= PW'($signed(vy_reg[t])) * PW'($signed(vy_reg[t]));
            end
        end
    end

    // stage 3: cross, dot and squared lengths
    logic signed [SW-1:0] cr_reg [NT], dt_reg [NT], nu_reg [NT], nv_reg [NT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3 && v2_reg) begin
            for (int t = 0; t < NT; t++) begin
                cr_reg[t] <= SW'(p_uxvy_reg[t]) - SW'(p_uyvx_reg[t]);
                dt_reg[t] <= SW'(p_uxvx_reg[t]) + SW'(p_uyvy_reg[t]);
                nu_reg[t] <= SW'(p_uxux_reg[t]) + SW'(p_uyuy_reg[t]);
                nv_reg[t] <= SW'(p_vxvx_reg[t]) + SW'(p_vyvy_reg[t]);
            end
        end
    end

    // stage 4: classify each test, combine into the meet flag, output register
    segi_pkg::orient_t orient_next [NT];
    segi_pkg::orient_t orient_reg [NT];
    logic              meet_next, meet_reg;

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            if (cr_reg[t] > 0) begin
                orient_next[t] = segi_pkg::ORIENT_CCW;
            end else if (cr_reg[t] < 0) begin
                orient_next[t] = segi_pkg::ORIENT_CW;
            end else if (dt_reg[t] < 0) begin
                orient_next[t] = segi_pkg::ORIENT_BACK;
            end else if (nv_reg[t] > nu_reg[t]) begin
                orient_next[t] = segi_pkg::ORIENT_FRONT;
            end else begin
                orient_next[t] = segi_pkg::ORIENT_ON;
            end
        end
        meet_next = segi_pkg::segments_meet_of(orient_next[0], orient_next[1],
                                               orient_next[2], orient_next[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv4) begin
            m_valid_reg <= v3_reg;
        end
        if (adv4 && v3_reg) begin
            orient_reg <= orient_next;
            meet_reg   <= meet_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(segi_pkg::M_TDATA_W - 1 - NT * OW)'(0),
                       orient_reg[3], orient_reg[2], orient_reg[1], orient_reg[0],
                       meet_reg};

`ifndef ASSERT_OFF
    // meet flag agrees with the four codes it leaves with
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == segi_pkg::segments_meet_of(
            segi_pkg::orient_t'(m_tdata[3:1]), segi_pkg::orient_t'(m_tdata[6:4]),
            segi_pkg::orient_t'(m_tdata[9:7]), segi_pkg::orient_t'(m_tdata[12:10])))
        else $error("meet flag disagrees with orientation codes");

    // input backs up only behind a stalled, full output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && v1_reg && v2_reg && v3_reg))
        else $error("input stalled while pipeline has room");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");

    // an accepted request is never dropped from stage 1 on a stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv2) |=> v1_reg)
        else $error("stage 1 request lost during stall");
`endif

endmodule
